// ===== rtl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Types and constants for the triangle circumcenter pipeline.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int CW = 32;   // coordinate width
  localparam int NW = 100;  // numerator magnitude width
  localparam int DW = 66;   // 2*|D| width
  localparam int QW = 42;   // quotient width after clamp
  localparam int SW = 66;   // squared radius width

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OFF_PLANE = 2'd1;
  localparam logic [1:0] ST_COLLINEAR = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  localparam logic [0:0] CFG_Z_TOL   = 1'd0;
  localparam logic [0:0] CFG_DET_TOL = 1'd1;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic        [31:0] radius;
    logic        [1:0]  status;
  } out_word_t;

  // Item state carried from the front end through the divider
  typedef struct packed {
    logic               fail;
    logic [1:0]         status;
    logic signed [32:0] ax;
    logic signed [32:0] ay;
    logic               nx_neg;
    logic               ny_neg;
    logic [NW-1:0]      nx_mag;
    logic [NW-1:0]      ny_mag;
    logic [DW-1:0]      den;
  } div_job_t;

  // Rounded offsets, handed to the center and radius stages
  typedef struct packed {
    logic               fail;
    logic [1:0]         status;
    logic signed [32:0] ax;
    logic signed [32:0] ay;
    logic signed [QW:0] ox;
    logic signed [QW:0] oy;
  } off_job_t;

endpackage

// ===== rtl/triangle_circumcenter_unit.sv =====
// Throughput: one word per cycle; the 42-stage divider and 33-stage square
// root each take one bit a stage. A stall freezes the whole pipeline.
// Reset: synchronous active-low rst_n clears valid bits and both tolerances.
// ----------------------------------------------------------------------------
// triangle_circumcenter_unit
// Circumcenter and circumradius of three Q16.16 points in the x-y plane.
// ----------------------------------------------------------------------------
module triangle_circumcenter_unit import tcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [30:0] z_tol_r;
  logic [31:0] det_tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_tol_r   <= '0;
      det_tol_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_Z_TOL:   z_tol_r   <= cfg_data[30:0];
        CFG_DET_TOL: det_tol_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic     en;
  logic     f_v, d_v;
  div_job_t f_d;
  off_job_t d_d;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  tcc_front u_front (
    .clk, .rst_n, .en,
    .in_v(in_valid && in_ready), .in_d(in_data),
    .z_tol(z_tol_r), .det_tol(det_tol_r),
    .out_v(f_v), .out_d(f_d)
  );

  tcc_div u_div (
    .clk, .rst_n, .en,
    .in_v(f_v), .in_d(f_d),
    .out_v(d_v), .out_d(d_d)
  );

  tcc_back u_back (
    .clk, .rst_n, .en,
    .in_v(d_v), .in_d(d_d),
    .out_v(out_valid), .out_d(out_data)
  );

endmodule

// ===== rtl/tcc_front.sv =====
// ----------------------------------------------------------------------------
// tcc_front
// Plane and determinant checks, edge products and numerators (4 stages).
// ----------------------------------------------------------------------------
module tcc_front import tcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  in_word_t    in_d,
  input  logic [30:0] z_tol,
  input  logic [31:0] det_tol,
  output logic        out_v,
  output div_job_t    out_d
);

  logic v1_r, v2_r, v3_r, v4_r;

  // stage 1: differences and z check
  logic signed [32:0] ax1_r, ay1_r, xba_r, yba_r, xca_r, yca_r;
  logic               off1_r;

  function automatic logic zbad(logic signed [31:0] z, logic [30:0] t);
    logic [32:0] m;
    m = z[31] ? 33'(-$signed({z[31], z})) : {1'b0, z};
    return m > {2'b0, t};
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r  <= 33'(in_d.a_x);
      ay1_r  <= 33'(in_d.a_y);
      xba_r  <= 33'(in_d.b_x) - 33'(in_d.a_x);
      yba_r  <= 33'(in_d.b_y) - 33'(in_d.a_y);
      xca_r  <= 33'(in_d.c_x) - 33'(in_d.a_x);
      yca_r  <= 33'(in_d.c_y) - 33'(in_d.a_y);
      off1_r <= zbad(in_d.a_z, z_tol) | zbad(in_d.b_z, z_tol) | zbad(in_d.c_z, z_tol);
    end
  end

  // stage 2: products of differences
  logic signed [65:0] p_xy_r, p_yx_r, p_xx_b_r, p_yy_b_r, p_xx_c_r, p_yy_c_r;
  logic signed [32:0] ax2_r, ay2_r, xba2_r, yba2_r, xca2_r, yca2_r;
  logic               off2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_xy_r   <= xba_r * yca_r;
      p_yx_r   <= yba_r * xca_r;
      p_xx_b_r <= xba_r * xba_r;
      p_yy_b_r <= yba_r * yba_r;
      p_xx_c_r <= xca_r * xca_r;
      p_yy_c_r <= yca_r * yca_r;
      ax2_r <= ax1_r; ay2_r <= ay1_r;
      xba2_r <= xba_r; yba2_r <= yba_r; xca2_r <= xca_r; yca2_r <= yca_r;
      off2_r <= off1_r;
    end
  end

  // stage 3: determinant, squared lengths, collinear check
  logic signed [66:0] det_r;
  logic        [66:0] ba_r, ca_r;
  logic signed [32:0] ax3_r, ay3_r, xba3_r, yba3_r, xca3_r, yca3_r;
  logic               off3_r, col3_r;
  logic signed [66:0] det_c;
  logic        [66:0] adet_c;

  always_comb begin
    det_c  = 67'(p_xy_r) - 67'(p_yx_r);
    adet_c = det_c[66] ? 67'(-det_c) : det_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= det_c;
      ba_r  <= 67'($unsigned(p_xx_b_r)) + 67'($unsigned(p_yy_b_r));
      ca_r  <= 67'($unsigned(p_xx_c_r)) + 67'($unsigned(p_yy_c_r));
      col3_r <= adet_c <= {35'b0, det_tol};
      ax3_r <= ax2_r; ay3_r <= ay2_r;
      xba3_r <= xba2_r; yba3_r <= yba2_r; xca3_r <= xca2_r; yca3_r <= yca2_r;
      off3_r <= off2_r;
    end
  end

  // stage 4: numerators (33 x 67 bit products, two partial products each)
  logic signed [100:0] nx_c, ny_c;

  function automatic logic signed [100:0] smul(logic signed [32:0] a, logic [66:0] b);
    logic signed [66:0] lo, hi;
    lo = a * $signed({1'b0, b[33:0]});
    hi = a * $signed({1'b0, b[66:34]});
    return 101'(lo) + (101'(hi) <<< 34);
  endfunction

  always_comb begin
    nx_c = smul(yca3_r, ba_r) - smul(yba3_r, ca_r);
    ny_c = smul(xba3_r, ca_r) - smul(xca3_r, ba_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d.fail   <= off3_r | col3_r;
      out_d.status <= off3_r ? ST_OFF_PLANE : (col3_r ? ST_COLLINEAR : ST_OK);
      out_d.ax     <= ax3_r;
      out_d.ay     <= ay3_r;
      out_d.nx_neg <= nx_c[100] ^ det_r[66];
      out_d.ny_neg <= ny_c[100] ^ det_r[66];
      out_d.nx_mag <= nx_c[100] ? NW'(-nx_c) : NW'(nx_c);
      out_d.ny_mag <= ny_c[100] ? NW'(-ny_c) : NW'(ny_c);
      out_d.den    <= det_r[66] ? DW'(-det_r) << 1 : DW'(det_r) << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
  end

  assign out_v = v4_r;

endmodule

// ===== rtl/tcc_div.sv =====
// ----------------------------------------------------------------------------
// tcc_div
// Pipelined restoring divider for both offsets, one quotient bit a stage,
// with round-half-away and clamp to 2^40 at the end.
// ----------------------------------------------------------------------------
module tcc_div import tcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_v,
  input  div_job_t in_d,
  output logic     out_v,
  output off_job_t out_d
);

  // quotient bits below 2^QB; a quotient of 2^QB or more is flagged up
  // front and clamped.
  localparam int QB = QW;

  logic     v_r [QB+1];
  div_job_t j_r [QB+1];
  logic [NW-1:0] rx_r [QB+1], ry_r [QB+1];
  logic [QB-1:0] qx_r [QB+1], qy_r [QB+1];
  logic          bx_r [QB+1], by_r [QB+1];

  // quotient >= 2^QB iff num >= den << QB
  always_ff @(posedge clk) begin
    if (en) begin
      j_r[0]  <= in_d;
      rx_r[0] <= in_d.nx_mag;
      ry_r[0] <= in_d.ny_mag;
      qx_r[0] <= '0;
      qy_r[0] <= '0;
      bx_r[0] <= (NW+QB+1)'(in_d.nx_mag) >= ((NW+QB+1)'(in_d.den) << QB);
      by_r[0] <= (NW+QB+1)'(in_d.ny_mag) >= ((NW+QB+1)'(in_d.den) << QB);
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_st
    localparam int SH = QB - 1 - s;
    logic [NW+QB:0] dsh;
    logic           gx, gy;
    assign dsh = (NW+QB+1)'(j_r[s].den) << SH;
    assign gx  = (NW+QB+1)'(rx_r[s]) >= dsh;
    assign gy  = (NW+QB+1)'(ry_r[s]) >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        j_r[s+1]  <= j_r[s];
        bx_r[s+1] <= bx_r[s];
        by_r[s+1] <= by_r[s];
        rx_r[s+1] <= gx ? NW'((NW+QB+1)'(rx_r[s]) - dsh) : rx_r[s];
        ry_r[s+1] <= gy ? NW'((NW+QB+1)'(ry_r[s]) - dsh) : ry_r[s];
        qx_r[s+1] <= qx_r[s] | (QB'(gx) << SH);
        qy_r[s+1] <= qy_r[s] | (QB'(gy) << SH);
      end
    end
  end

  localparam logic [QB:0] BIG = (QB+1)'(1) << 40;

  function automatic logic signed [QW:0] fin(logic big, logic [QB-1:0] q,
                                            logic [NW-1:0] r, logic [DW-1:0] d,
                                            logic neg);
    logic [QB:0] qq;
    qq = {1'b0, q} + (QB+1)'(({1'b0, r} << 1) >= (NW+1)'(d));
    if (big || qq > BIG) qq = BIG;
    return neg ? -$signed(qq) : $signed(qq);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      out_d.fail   <= j_r[QB].fail;
      out_d.status <= j_r[QB].status;
      out_d.ax     <= j_r[QB].ax;
      out_d.ay     <= j_r[QB].ay;
      out_d.ox <= fin(bx_r[QB], qx_r[QB], rx_r[QB], j_r[QB].den, j_r[QB].nx_neg);
      out_d.oy <= fin(by_r[QB], qy_r[QB], ry_r[QB], j_r[QB].den, j_r[QB].ny_neg);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QB; i++) v_r[i] <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
      for (int i = 0; i < QB; i++) v_r[i+1] <= v_r[i];
      out_v <= v_r[QB];
    end
  end

endmodule

// ===== rtl/tcc_back.sv =====
// ----------------------------------------------------------------------------
// tcc_back
// Center saturation, squared radius and pipelined square root.
// ----------------------------------------------------------------------------
module tcc_back import tcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_v,
  input  off_job_t  in_d,
  output logic      out_v,
  output out_word_t out_d
);

  localparam int RB = 33;  // root bits

  typedef struct packed {
    logic        fail;
    logic [1:0]  status;
    logic [31:0] cx;
    logic [31:0] cy;
    logic        ovf;
    logic        rsat;
  } back_t;

  function automatic logic [31:0] sat(logic signed [QW+1:0] v, output logic o);
    o = 1'b0;
    if (v > (QW+2)'(32'sh7fffffff)) begin o = 1'b1; return 32'h7fffffff; end
    if (v < -(QW+2)'(33'sh080000000)) begin o = 1'b1; return 32'h80000000; end
    return v[31:0];
  endfunction

  // stage A: center, magnitudes
  back_t       a_r;
  logic [31:0] mx_r, my_r;
  logic [QW:0] ux_c, uy_c;
  logic        o1, o2;
  logic [31:0] scx, scy;

  always_comb begin
    ux_c = in_d.ox[QW] ? (QW+1)'(-in_d.ox) : (QW+1)'(in_d.ox);
    uy_c = in_d.oy[QW] ? (QW+1)'(-in_d.oy) : (QW+1)'(in_d.oy);
    scx  = sat((QW+2)'(in_d.ax) + (QW+2)'(in_d.ox), o1);
    scy  = sat((QW+2)'(in_d.ay) + (QW+2)'(in_d.oy), o2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r.fail   <= in_d.fail;
      a_r.status <= in_d.status;
      a_r.cx     <= scx;
      a_r.cy     <= scy;
      a_r.ovf    <= o1 | o2;
      a_r.rsat   <= (ux_c[QW:32] != '0) | (uy_c[QW:32] != '0);
      mx_r <= ux_c[31:0];
      my_r <= uy_c[31:0];
    end
  end

  // stage B: squares
  logic [63:0] sx_r, sy_r;
  back_t       b_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= mx_r * mx_r;
      sy_r <= my_r * my_r;
      b_r  <= a_r;
    end
  end

  // stage C: sum (65 bits; a carry out means saturate)
  logic [64:0] s_r;
  back_t       c_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= 65'(sx_r) + 65'(sy_r);
      c_r <= b_r;
    end
  end

  // square root, one result bit a stage
  back_t       q_r   [RB+1];
  logic [SW-1:0] rem_r [RB+1];
  logic [RB-1:0] res_r [RB+1];
  back_t         qin_c;

  always_comb begin
    qin_c      = c_r;
    qin_c.rsat = c_r.rsat | s_r[64];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0]      <= qin_c;
      rem_r[0]    <= SW'(s_r[63:0]);
      res_r[0]    <= '0;
    end
  end

  for (genvar k = 0; k < RB; k++) begin : g_sq
    localparam int B = RB - 1 - k;
    logic [SW-1:0] trial;
    logic          ge;
    assign trial = (SW'(res_r[k]) << (B + 1)) | (SW'(1) << (2 * B));
    assign ge    = rem_r[k] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k+1]   <= q_r[k];
        rem_r[k+1] <= ge ? rem_r[k] - trial : rem_r[k];
        res_r[k+1] <= res_r[k] | (RB'(ge) << B);
      end
    end
  end

  logic [RB:0] rr_c;
  logic        big_c;
  always_comb begin
    rr_c  = {1'b0, res_r[RB]} + (RB+1)'(rem_r[RB] > SW'(res_r[RB]));
    big_c = q_r[RB].rsat | (rr_c[RB:32] != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (q_r[RB].fail) begin
        out_d.center_x <= '0;
        out_d.center_y <= '0;
        out_d.radius   <= '0;
        out_d.status   <= q_r[RB].status;
      end else begin
        out_d.center_x <= q_r[RB].cx;
        out_d.center_y <= q_r[RB].cy;
        out_d.radius   <= big_c ? 32'hffffffff : rr_c[31:0];
        out_d.status   <= (q_r[RB].ovf | big_c) ? ST_OVERFLOW : ST_OK;
      end
    end
  end

  logic vA_r, vB_r, vC_r;
  logic vq_r [RB+1];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vA_r <= 1'b0; vB_r <= 1'b0; vC_r <= 1'b0; out_v <= 1'b0;
      for (int i = 0; i <= RB; i++) vq_r[i] <= 1'b0;
    end else if (en) begin
      vA_r <= in_v; vB_r <= vA_r; vC_r <= vB_r; vq_r[0] <= vC_r;
      for (int i = 0; i < RB; i++) vq_r[i+1] <= vq_r[i];
      out_v <= vq_r[RB];
    end
  end

endmodule

// ===== dv/tcc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_checker
// Watches the word channels and the register port of the circumcenter unit.
// Computes the expected center, radius and status of every accepted input
// word and compares them with the output words in order.
// ----------------------------------------------------------------------------
module tcc_checker import tcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          checked
);

  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam longint OLIM = 64'sd4294967296;

  logic [30:0] z_tol;
  logic [31:0] det_tol;
  out_word_t   expected_q[$];

  function automatic logic [63:0] zmag(logic signed [31:0] z);
    longint v;
    v = z;
    return (v < 0) ? -v : v;
  endfunction

  // n/d rounded to nearest, ties away from zero, magnitude clamped to 2^40
  function automatic longint round_quot(logic signed [127:0] n, logic signed [127:0] d);
    logic [127:0] an, ad, q, rm;
    longint m;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q  = an / ad;
    rm = an % ad;
    if ((rm << 1) >= ad) q = q + 1;
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    m = q[63:0];
    return ((n < 0) != (d < 0)) ? -m : m;
  endfunction

  function automatic logic [63:0] sqrt_round(logic [63:0] s);
    logic [63:0] res, t, rem;
    res = 0;
    for (int i = 31; i >= 0; i--) begin
      t = res | (64'd1 << i);
      if (t * t <= s) res = t;
    end
    rem = s - res * res;
    if (rem > res) res = res + 1;
    return res;
  endfunction

  function automatic out_word_t circumcenter(in_word_t w);
    logic signed [127:0] ax, ay, xba, yba, xca, yca, det, adet, ba, ca, nx, ny;
    longint ox, oy, cxs, cys, aox, aoy;
    logic [127:0] sq;
    logic [63:0] rad;
    logic ovf;
    out_word_t r;
    r = '0;
    if (zmag(w.a_z) > {33'd0, z_tol} || zmag(w.b_z) > {33'd0, z_tol} ||
        zmag(w.c_z) > {33'd0, z_tol}) begin
      r.status = ST_OFF_PLANE;
      return r;
    end
    ax = w.a_x;
    ay = w.a_y;
    xba = w.b_x - ax;
    yba = w.b_y - ay;
    xca = w.c_x - ax;
    yca = w.c_y - ay;
    det = xba * yca - yba * xca;
    adet = (det < 0) ? -det : det;
    if (adet <= $signed({96'd0, det_tol})) begin
      r.status = ST_COLLINEAR;
      return r;
    end
    ba = xba * xba + yba * yba;
    ca = xca * xca + yca * yca;
    nx = yca * ba - yba * ca;
    ny = xba * ca - xca * ba;
    ox = round_quot(nx, det <<< 1);
    oy = round_quot(ny, det <<< 1);
    ovf = 1'b0;
    cxs = ax[63:0] + ox;
    cys = ay[63:0] + oy;
    if (cxs > CMAX) begin cxs = CMAX; ovf = 1'b1; end
    if (cxs < CMIN) begin cxs = CMIN; ovf = 1'b1; end
    if (cys > CMAX) begin cys = CMAX; ovf = 1'b1; end
    if (cys < CMIN) begin cys = CMIN; ovf = 1'b1; end
    aox = (ox < 0) ? -ox : ox;
    aoy = (oy < 0) ? -oy : oy;
    if (aox >= OLIM || aoy >= OLIM) begin
      rad = 64'hffffffff;
      ovf = 1'b1;
    end else begin
      sq = {64'd0, aox} * {64'd0, aox} + {64'd0, aoy} * {64'd0, aoy};
      if (sq >= (128'd1 << 64)) begin
        rad = 64'hffffffff;
        ovf = 1'b1;
      end else begin
        rad = sqrt_round(sq[63:0]);
        if (rad > 64'hffffffff) begin
          rad = 64'hffffffff;
          ovf = 1'b1;
        end
      end
    end
    r.center_x = cxs[31:0];
    r.center_y = cys[31:0];
    r.radius   = rad[31:0];
    r.status   = ovf ? ST_OVERFLOW : ST_OK;
    return r;
  endfunction

  assign pending = expected_q.size();

  initial begin
    errors  = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      z_tol   <= '0;
      det_tol <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_Z_TOL) z_tol <= cfg_data[30:0];
        else if (cfg_index == CFG_DET_TOL) det_tol <= cfg_data;
      end
      if (in_valid && in_ready) expected_q.push_back(circumcenter(in_data));
      if (out_valid && out_ready) begin
        checked++;
        if (expected_q.size() == 0) begin
          $error("output word with nothing expected");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_data.center_x !== e.center_x) begin
            $error("center_x: expected %0d, got %0d", e.center_x, out_data.center_x);
            errors++;
          end
          if (out_data.center_y !== e.center_y) begin
            $error("center_y: expected %0d, got %0d", e.center_y, out_data.center_y);
            errors++;
          end
          if (out_data.radius !== e.radius) begin
            $error("radius: expected %0d, got %0d", e.radius, out_data.radius);
            errors++;
          end
          if (out_data.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_data.status);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the triangle circumcenter unit: directed corner triangles,
// then random, collinear, near-collinear and off-plane triangles under
// several tolerance settings and idle/stall mixes. Checking is done by
// tcc_checker.
// ----------------------------------------------------------------------------
module testbench;
  import tcc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_data;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors;
  int          pending;
  int          checked;
  int          idle_pct;
  int          stall_pct;
  logic [30:0] z_cur;
  int          sent;

  triangle_circumcenter_unit i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  tcc_checker i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .cfg_we, .cfg_index, .cfg_data,
    .errors, .pending, .checked
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  initial begin
    #40_000_000;
    $display("FAIL triangle_circumcenter_unit");
    $finish;
  end

  task automatic send(in_word_t w);
    if ($urandom_range(99, 0) < idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_Z_TOL) z_cur = val[30:0];
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  function automatic logic signed [31:0] plane_z;
    logic [31:0] m;
    m = $urandom_range({1'b0, z_cur}, 0);
    if ($urandom_range(7, 0) == 0) m = {1'b0, z_cur};
    return $urandom_range(1, 0) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] coord(int sh);
    return $signed($urandom) >>> sh;
  endfunction

  function automatic in_word_t triangle;
    in_word_t w;
    int sh, t, s;
    logic signed [31:0] dx, dy;
    sh = $urandom_range(14, 0);
    w = '{coord(sh), coord(sh), plane_z(), coord(sh), coord(sh), plane_z(),
          coord(sh), coord(sh), plane_z()};
    case ($urandom_range(9, 0))
      0: w = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom};
      6, 7: begin
        dx = coord(21);
        dy = coord(21);
        t = $signed($urandom_range(200, 0)) - 100;
        s = $signed($urandom_range(200, 0)) - 100;
        w.a_x = coord(4);
        w.a_y = coord(4);
        w.b_x = w.a_x + t * dx;
        w.b_y = w.a_y + t * dy;
        w.c_x = w.a_x + s * dx + $signed($urandom_range(2, 0)) - 1;
        w.c_y = w.a_y + s * dy;
      end
      8: begin
        case ($urandom_range(2, 0))
          0: w.a_z = $urandom_range(1, 0) ? $signed({1'b0, z_cur}) + 1 : $urandom;
          1: w.b_z = -$signed({1'b0, z_cur}) - 1;
          default: w.c_z = $urandom;
        endcase
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic run_phase(int n, int ip, int sp, bit hold);
    idle_pct  = ip;
    stall_pct = sp;
    for (int i = 0; i < n; i++) begin
      send(triangle());
      if (hold && i == n / 2) while (pending != 0) @(negedge clk);
    end
    drain();
  endtask

  localparam logic signed [31:0] MX = 32'sh7fffffff;
  localparam logic signed [31:0] MN = -32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_Z_TOL;
    cfg_data  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    z_cur     = '0;
    sent      = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // corner triangles at reset tolerances
    send('0);
    send('{MX, MX, 0, MX, MX, 0, MX, MX, 0});
    send('{MN, MN, 0, MN, MN, 0, MN, MN, 0});
    send('{0, 0, 0, ONE, 0, 0, 0, ONE, 0});
    send('{MN, MN, 0, MX, MN, 0, MN, MX, 0});
    send('{MX, MN, 0, MN, MX, 0, MX, MX, 0});
    send('{0, 0, 0, MX, 0, 0, MN, 1, 0});
    send('{0, 0, 0, 1, 0, 0, 0, 1, 0});
    send('{0, 0, 1, ONE, 0, 0, 0, ONE, 0});
    send('{0, 0, 0, ONE, 0, MN, 0, ONE, 0});
    send('{0, 0, 0, ONE, 0, 0, 0, ONE, MX});
    send('{5, 7, 0, 5 + 3 * ONE, 7 + 3, 0, 5 + 9 * ONE, 7 + 10, 0});
    send('{-ONE, -ONE, 0, ONE, ONE, 0, 3 * ONE, 3 * ONE, 0});
    drain();

    write_reg(CFG_Z_TOL, 32'hffffffff);
    write_reg(CFG_DET_TOL, 32'hffffffff);
    send('{0, 0, MN + 1, ONE, 0, MX, 0, ONE, 0});
    send('{0, 0, MN, ONE, 0, 0, 0, ONE, 0});
    send('{0, 0, 0, ONE, 0, 0, 0, 1, 0});
    send('{0, 0, 0, ONE, 0, 0, 0, ONE, 0});
    send('{0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10001, 0});
    drain();
    run_phase(230, 63, 0, 1'b0);

    write_reg(CFG_Z_TOL, 32'h00010000);
    write_reg(CFG_DET_TOL, 32'd0);
    run_phase(230, 0, 63, 1'b1);

    write_reg(CFG_Z_TOL, $urandom);
    write_reg(CFG_DET_TOL, $urandom_range(1 << 20, 0));
    run_phase(230, 16, 16, 1'b0);

    write_reg(CFG_Z_TOL, 32'd0);
    write_reg(CFG_DET_TOL, 32'd1);
    run_phase(230, 0, 0, 1'b0);

    write_reg(CFG_Z_TOL, 32'h7fffffff);
    write_reg(CFG_DET_TOL, $urandom);
    run_phase(230, 63, 63, 1'b1);

    $display("Sent %0d triangles over six tolerance settings, %0d results checked,",
             sent, checked);
    $display("with sender gaps, receiver stalls and a full drain mid-stream.");
    if (errors == 0) begin
      $display("PASS triangle_circumcenter_unit");
    end else begin
      $display("FAIL triangle_circumcenter_unit");
    end
    $finish;
  end

endmodule
